// ===== hw/rtl/smeu_pkg.sv =====
// ----------------------------------------------------------------------------
// smeu_pkg: shared types and constants of the stack machine execute unit
// Opcodes, status codes, field widths and the controller/datapath interface.
// ----------------------------------------------------------------------------
package smeu_pkg;

    localparam int DATA_W   = 32;
    localparam int LINE_W   = 11;
    localparam int OP_W     = 4;
    localparam int TGT_W    = 10;
    localparam int SLOT_W   = 6;
    localparam int STAT_W   = 4;
    localparam int IN_W     = 56;
    localparam int OUT_W    = 48;

    // Opcodes
    localparam logic [OP_W-1:0] OP_ADD    = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB    = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL    = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV    = 4'd3;
    localparam logic [OP_W-1:0] OP_ASSIGN = 4'd4;
    localparam logic [OP_W-1:0] OP_VAR    = 4'd5;
    localparam logic [OP_W-1:0] OP_JMP    = 4'd6;
    localparam logic [OP_W-1:0] OP_JMPEQ  = 4'd7;
    localparam logic [OP_W-1:0] OP_JMPGT  = 4'd8;
    localparam logic [OP_W-1:0] OP_JMPLT  = 4'd9;
    localparam logic [OP_W-1:0] OP_CONST  = 4'd10;
    localparam logic [OP_W-1:0] OP_PRINT  = 4'd11;
    localparam logic [OP_W-1:0] OP_HALT   = 4'd12;

    // Status codes
    localparam logic [STAT_W-1:0] ST_RUN     = 4'd0;
    localparam logic [STAT_W-1:0] ST_HALTED  = 4'd1;
    localparam logic [STAT_W-1:0] ST_DIVZERO = 4'd2;
    localparam logic [STAT_W-1:0] ST_BADJUMP = 4'd3;
    localparam logic [STAT_W-1:0] ST_UNDEF   = 4'd4;
    localparam logic [STAT_W-1:0] ST_UNDER   = 4'd5;
    localparam logic [STAT_W-1:0] ST_OVER    = 4'd6;
    localparam logic [STAT_W-1:0] ST_EARLY   = 4'd7;
    localparam logic [STAT_W-1:0] ST_PASTEND = 4'd8;
    localparam logic [STAT_W-1:0] ST_BADOP   = 4'd9;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // latch the input item, first stack read
        logic cap_r;      // capture the top-of-stack word
        logic rd_second;  // address the second stack word
        logic div_start;  // start the divider
        logic use_quot;   // take the quotient as the result
        logic commit;     // update state and the output register
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic go_div;
        logic div_last;
        logic stopped;
    } sts_t;

endpackage

// ===== hw/rtl/smeu_ram.sv =====
// ----------------------------------------------------------------------------
// smeu_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smeu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/smeu_ctrl.sv =====
// ----------------------------------------------------------------------------
// smeu_ctrl: execute unit controller
// Sequences the stack reads, the divider and the result transfer.
// ----------------------------------------------------------------------------
module smeu_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  smeu_pkg::sts_t    sts,
    output smeu_pkg::cmd_t    cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD2  = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       mvalid_reg, mvalid_next;
    logic       out_free;

    assign out_free = !mvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.rd_second = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RD2;
                end
            end
            S_RD2:
            begin
                cmd.cap_r  = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (sts.go_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.use_quot = 1'b1;
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid flag
    always_comb
    begin
        mvalid_next = mvalid_reg;
        if (cmd.commit)
        begin
            mvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

// ===== hw/rtl/smeu_dp.sv =====
// ----------------------------------------------------------------------------
// smeu_dp: execute unit datapath
// Operand stack and variable RAMs, counters, ALU, divider and result register.
// ----------------------------------------------------------------------------
module smeu_dp #(
    parameter int STACK_DEPTH = 64,
    parameter int VAR_SLOTS   = 64,
    parameter int MAX_PROGRAM = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [smeu_pkg::OP_W-1:0]           in_op,
    input  logic [smeu_pkg::DATA_W-1:0]         in_imm,
    input  logic [smeu_pkg::TGT_W-1:0]          in_tgt,
    input  logic [smeu_pkg::SLOT_W-1:0]         in_slot,
    input  logic                                cfg_we,
    input  logic [smeu_pkg::LINE_W-1:0]         cfg_wdata,
    input  smeu_pkg::cmd_t                      cmd,
    output smeu_pkg::sts_t                      sts,
    output logic [smeu_pkg::OUT_W-1:0]          out_data
);

    localparam int SAW   = $clog2(STACK_DEPTH);
    localparam int SPW   = $clog2(STACK_DEPTH + 1);
    localparam int VD    = (VAR_SLOTS < 2) ? 2 : VAR_SLOTS;
    localparam int VW    = $clog2(VD);
    localparam int LW    = smeu_pkg::LINE_W;
    localparam int DW    = smeu_pkg::DATA_W;
    localparam int CMPW  = 18;

    // Architectural and item registers
    logic [LW-1:0]                 plen_reg;
    logic [LW-1:0]                 pc_reg;
    logic [SPW-1:0]                sp_reg;
    logic                          stopped_reg;
    logic [smeu_pkg::STAT_W-1:0]   code_reg;
    logic [VAR_SLOTS-1:0]          def_reg;
    logic [smeu_pkg::OP_W-1:0]     op_reg;
    logic [DW-1:0]                 imm_reg;
    logic [smeu_pkg::TGT_W-1:0]    tgt_reg;
    logic [smeu_pkg::SLOT_W-1:0]   slot_reg;
    logic [DW-1:0]                 r_reg;
    logic [smeu_pkg::OUT_W-1:0]    out_reg;

    // Divider registers
    logic [DW-1:0]                 rem_reg;
    logic [DW-1:0]                 quo_reg;
    logic [DW-1:0]                 den_reg;
    logic [4:0]                    cnt_reg;
    logic                          busy_reg;
    logic                          neg_reg;

    // Memory ports
    logic [SAW-1:0]                st_raddr, st_waddr;
    logic [DW-1:0]                 st_rdata, st_wdata;
    logic                          st_we;
    logic [VW-1:0]                 va, var_raddr;
    logic [DW-1:0]                 var_rdata;
    logic                          var_we;

    // Evaluation signals
    logic [LW-1:0]                 len, nxt;
    logic [smeu_pkg::STAT_W-1:0]   st;
    logic [DW-1:0]                 l, r, res, quot;
    logic [1:0]                    pop;
    logic                          push, take, slot_ok, defd;
    logic [SPW-1:0]                sp_new;
    logic [DW:0]                   sh;
    logic                          ge;

    assign l = st_rdata;
    assign r = r_reg;
    assign va = VW'(slot_reg);
    assign slot_ok = ({{(CMPW - smeu_pkg::SLOT_W){1'b0}}, slot_reg} < CMPW'(VAR_SLOTS));
    assign defd = slot_ok && def_reg[va];
    assign len = ({{(CMPW - LW){1'b0}}, plen_reg} > CMPW'(MAX_PROGRAM))
                 ? LW'(MAX_PROGRAM) : plen_reg;
    assign quot = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

    // Read addresses: top of stack at accept, second word afterwards
    assign st_raddr  = cmd.rd_second ? SAW'(sp_reg - SPW'(2)) : SAW'(sp_reg - SPW'(1));
    assign var_raddr = cmd.load ? VW'(in_slot) : va;

    smeu_ram #(.WIDTH(DW), .DEPTH(STACK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    smeu_ram #(.WIDTH(DW), .DEPTH(VD)) u_vars (
        .clk   (clk),
        .we    (var_we),
        .waddr (va),
        .wdata (r_reg),
        .raddr (var_raddr),
        .rdata (var_rdata)
    );

    // Instruction evaluation
    always_comb
    begin
        st   = smeu_pkg::ST_RUN;
        nxt  = pc_reg + 1'b1;
        pop  = 2'd0;
        push = 1'b0;
        res  = imm_reg;
        take = 1'b0;
        if (pc_reg >= len)
        begin
            st = smeu_pkg::ST_PASTEND;
        end
        else
        begin
            case (op_reg)
                smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL, smeu_pkg::OP_DIV:
                begin
                    if (sp_reg < SPW'(2))
                    begin
                        st = smeu_pkg::ST_UNDER;
                    end
                    else
                    begin
                        pop  = 2'd2;
                        push = 1'b1;
                        case (op_reg)
                            smeu_pkg::OP_ADD: res = l + r;
                            smeu_pkg::OP_SUB: res = l - r;
                            smeu_pkg::OP_MUL: res = l * r;
                            default:          res = quot;
                        endcase
                        if (op_reg == smeu_pkg::OP_DIV && r == '0)
                        begin
                            st = smeu_pkg::ST_DIVZERO;
                        end
                    end
                end
                smeu_pkg::OP_JMPEQ, smeu_pkg::OP_JMPGT, smeu_pkg::OP_JMPLT:
                begin
                    if (sp_reg < SPW'(2))
                    begin
                        st = smeu_pkg::ST_UNDER;
                    end
                    else
                    begin
                        pop = 2'd2;
                        case (op_reg)
                            smeu_pkg::OP_JMPEQ: take = (l == r);
                            smeu_pkg::OP_JMPGT: take = ($signed(l) > $signed(r));
                            default:            take = ($signed(l) < $signed(r));
                        endcase
                        if (take)
                        begin
                            if ({1'b0, tgt_reg} >= len)
                            begin
                                st = smeu_pkg::ST_BADJUMP;
                            end
                            else
                            begin
                                nxt = {1'b0, tgt_reg};
                            end
                        end
                    end
                end
                smeu_pkg::OP_ASSIGN:
                begin
                    if (sp_reg == '0)
                    begin
                        st = smeu_pkg::ST_UNDER;
                    end
                    else
                    begin
                        pop = 2'd1;
                    end
                end
                smeu_pkg::OP_VAR, smeu_pkg::OP_CONST:
                begin
                    if (op_reg == smeu_pkg::OP_VAR && !defd)
                    begin
                        st = smeu_pkg::ST_UNDEF;
                    end
                    else if (sp_reg >= SPW'(STACK_DEPTH))
                    begin
                        st = smeu_pkg::ST_OVER;
                    end
                    else
                    begin
                        push = 1'b1;
                        res  = (op_reg == smeu_pkg::OP_VAR) ? var_rdata : imm_reg;
                    end
                end
                smeu_pkg::OP_JMP:
                begin
                    if ({1'b0, tgt_reg} >= len)
                    begin
                        st = smeu_pkg::ST_BADJUMP;
                    end
                    else
                    begin
                        nxt = {1'b0, tgt_reg};
                    end
                end
                smeu_pkg::OP_PRINT:
                begin
                    if (!defd)
                    begin
                        st = smeu_pkg::ST_UNDEF;
                    end
                end
                smeu_pkg::OP_HALT:
                begin
                    st = (nxt == len) ? smeu_pkg::ST_HALTED : smeu_pkg::ST_EARLY;
                end
                default:
                begin
                    st = smeu_pkg::ST_BADOP;
                end
            endcase
        end
    end

    // Stack and variable writes happen only on a successful commit
    assign sp_new   = sp_reg - SPW'(pop) + SPW'(push);
    assign st_waddr = (pop == 2'd2) ? SAW'(sp_reg - SPW'(2)) : SAW'(sp_reg);
    assign st_wdata = res;
    assign st_we    = cmd.commit && !stopped_reg && (st == smeu_pkg::ST_RUN) && push;
    assign var_we   = cmd.commit && !stopped_reg && (st == smeu_pkg::ST_RUN)
                      && (op_reg == smeu_pkg::OP_ASSIGN) && slot_ok;

    assign sts.go_div   = !stopped_reg && (st == smeu_pkg::ST_RUN)
                          && (op_reg == smeu_pkg::OP_DIV) && !cmd.use_quot;
    assign sts.div_last = busy_reg && (cnt_reg == 5'd31);
    assign sts.stopped  = stopped_reg;
    assign out_data     = out_reg;

    // Restoring divider step on magnitudes
    assign sh = {rem_reg, quo_reg[DW-1]};
    assign ge = (sh >= {1'b0, den_reg});

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg    <= LW'(1);
            pc_reg      <= '0;
            sp_reg      <= '0;
            stopped_reg <= 1'b0;
            code_reg    <= smeu_pkg::ST_RUN;
            def_reg     <= '0;
            busy_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                plen_reg <= cfg_wdata;
            end
            if (cmd.commit && !stopped_reg)
            begin
                if (st != smeu_pkg::ST_RUN)
                begin
                    stopped_reg <= 1'b1;
                    code_reg    <= st;
                end
                else
                begin
                    pc_reg <= nxt;
                    sp_reg <= sp_new;
                end
            end
            if (var_we)
            begin
                def_reg[va] <= 1'b1;
            end
            if (cmd.div_start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_op;
            imm_reg  <= in_imm;
            tgt_reg  <= in_tgt;
            slot_reg <= in_slot;
        end
        if (cmd.cap_r)
        begin
            r_reg <= st_rdata;
        end
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= l[DW-1] ? (~l + 1'b1) : l;
            den_reg <= r[DW-1] ? (~r + 1'b1) : r;
            neg_reg <= l[DW-1] ^ r[DW-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? DW'(sh - {1'b0, den_reg}) : DW'(sh);
            quo_reg <= {quo_reg[DW-2:0], ge};
        end
        // Result fields: next_line, print_valid, print_value, status
        if (cmd.commit)
        begin
            if (stopped_reg)
            begin
                out_reg <= {code_reg, {DW{1'b0}}, 1'b0, pc_reg};
            end
            else if (st != smeu_pkg::ST_RUN)
            begin
                out_reg <= {st, {DW{1'b0}}, 1'b0, pc_reg};
            end
            else if (op_reg == smeu_pkg::OP_PRINT)
            begin
                out_reg <= {smeu_pkg::ST_RUN, var_rdata, 1'b1, nxt};
            end
            else
            begin
                out_reg <= {smeu_pkg::ST_RUN, {DW{1'b0}}, 1'b0, nxt};
            end
        end
    end

endmodule

// ===== hw/rtl/stack_machine_execute_unit.sv =====
// ----------------------------------------------------------------------------
// stack_machine_execute_unit: 32-bit stack machine instruction executor
// Executes one instruction per input transfer and returns one result.
// ----------------------------------------------------------------------------
//  Channel | Direction | Fields
//  s_*     | in        | op, immediate, jump_target, var_index
//  m_*     | out       | next_line, print_valid, print_value, status
//  cfg_*   | in        | program_length
//
//  An instruction is accepted in S_IDLE, which reads the top stack word, then
//  S_RD2 reads the second word and S_EXEC commits; a division adds S_DIV and
//  S_FIN, as a restoring divider makes one quotient bit per cycle.
//  Stack operands come from a single-read-port RAM, one word per cycle.
//  The result register lets the next instruction be accepted while a
//  result waits; a stalled output holds the next commit.
//  Reset clears counters, defined marks and the stop flag at once.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit #(
    parameter int STACK_DEPTH = 64,
    parameter int VAR_SLOTS   = 64,
    parameter int MAX_PROGRAM = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op[3:0], immediate[35:4], jump_target[45:36], var_index[51:46], zeros
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // next_line[10:0], print_valid[11], print_value[43:12], status[47:44]
    output logic [47:0] m_tdata,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata
);

    smeu_pkg::cmd_t cmd;
    smeu_pkg::sts_t sts;

    smeu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    smeu_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .VAR_SLOTS   (VAR_SLOTS),
        .MAX_PROGRAM (MAX_PROGRAM)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_op     (s_tdata[3:0]),
        .in_imm    (s_tdata[35:4]),
        .in_tgt    (s_tdata[45:36]),
        .in_slot   (s_tdata[51:46]),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (m_tdata)
    );

`ifndef NO_ASSERTIONS
    // One instruction in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("accept while an instruction is in flight");

    // A stop is permanent until reset
    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        sts.stopped |=> sts.stopped)
        else $error("stop flag cleared");

    // An error or halt result never carries a printed value
    a_no_print_on_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[47:44] != smeu_pkg::ST_RUN) |-> !m_tdata[11])
        else $error("printed value on a stopping result");
`endif

endmodule

// ===== tb/sv/stack_machine_execute_unit_tb.sv =====
// ----------------------------------------------------------------------------
// stack_machine_execute_unit_tb: self-checking bench of the instruction executor
// Drives instruction transfers with random idle and stall bursts, and predicts
// each result with a behavioral copy of the machine. Most stimulus is legal
// code that keeps the machine running; the run ends with a stopping sequence.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit_tb;

    localparam int PROG_MAX    = 1024;
    localparam int STK_DEPTH   = 64;
    localparam int SLOTS       = 64;
    localparam int DRAIN_WAIT  = 40;
    localparam int STALL_LIMIT = 4000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // op, immediate, jump_target, var_index, zeros
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // next_line, print_valid, print_value, status
    logic        cfg_we;
    logic [10:0] cfg_wdata;

    stack_machine_execute_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Behavioral machine state used for prediction.
    int unsigned prog_len;
    int unsigned run_pc;
    logic [31:0] stk [STK_DEPTH];
    int unsigned sp;
    logic [31:0] var_val [SLOTS];
    logic        var_def [SLOTS];
    logic        halted;
    logic [3:0]  halt_code;

    logic [47:0] pending_results [$];
    int          error_count;
    int          quiet_cycles;
    bit          no_idle;
    int          out_stall;

    typedef struct {
        logic [3:0]  op;
        logic [31:0] imm;
        logic [9:0]  tgt;
        logic [5:0]  slot;
        bit          typed;
        logic [10:0] line;
        logic [3:0]  st;
    } instr_row_t;

    instr_row_t directed_rows [] = '{
        '{smeu_pkg::OP_CONST,  32'h7fffffff, 10'd0, 6'd0,  1, 11'd1, smeu_pkg::ST_RUN},
        '{smeu_pkg::OP_CONST,  32'h00000001, 10'd0, 6'd0,  0, 11'd0, smeu_pkg::ST_RUN},
        '{smeu_pkg::OP_ADD,    32'h0,        10'd0, 6'd0,  0, 11'd0, smeu_pkg::ST_RUN},
        '{smeu_pkg::OP_ASSIGN, 32'h0,        10'd0, 6'd63, 0, 11'd0, smeu_pkg::ST_RUN},
        '{smeu_pkg::OP_VAR,    32'h0,        10'd0, 6'd63, 0, 11'd0, smeu_pkg::ST_RUN},
        '{smeu_pkg::OP_CONST,  32'h80000000, 10'd0, 6'd0,  0, 11'd0, smeu_pkg::ST_RUN},
        '{smeu_pkg::OP_CONST,  32'hffffffff, 10'd0, 6'd0,  0, 11'd0, smeu_pkg::ST_RUN},
        '{smeu_pkg::OP_DIV,    32'h0,        10'd0, 6'd0,  0, 11'd0, smeu_pkg::ST_RUN},
        '{smeu_pkg::OP_CONST,  32'h00000007, 10'd0, 6'd0,  0, 11'd0, smeu_pkg::ST_RUN},
        '{smeu_pkg::OP_CONST,  32'hfffffffe, 10'd0, 6'd0,  0, 11'd0, smeu_pkg::ST_RUN},
        '{smeu_pkg::OP_DIV,    32'h0,        10'd0, 6'd0,  0, 11'd0, smeu_pkg::ST_RUN},
        '{smeu_pkg::OP_SUB,    32'h0,        10'd0, 6'd0,  0, 11'd0, smeu_pkg::ST_RUN},
        '{smeu_pkg::OP_CONST,  32'h00000003, 10'd0, 6'd0,  0, 11'd0, smeu_pkg::ST_RUN},
        '{smeu_pkg::OP_CONST,  32'h00000005, 10'd0, 6'd0,  0, 11'd0, smeu_pkg::ST_RUN},
        '{smeu_pkg::OP_MUL,    32'h0,        10'd0, 6'd0,  0, 11'd0, smeu_pkg::ST_RUN},
        '{smeu_pkg::OP_ASSIGN, 32'h0,        10'd0, 6'd0,  0, 11'd0, smeu_pkg::ST_RUN},
        '{smeu_pkg::OP_PRINT,  32'h0,        10'd0, 6'd0,  0, 11'd0, smeu_pkg::ST_RUN},
        '{smeu_pkg::OP_PRINT,  32'h0,        10'd0, 6'd63, 0, 11'd0, smeu_pkg::ST_RUN},
        '{smeu_pkg::OP_CONST,  32'h00000004, 10'd0, 6'd0,  0, 11'd0, smeu_pkg::ST_RUN},
        '{smeu_pkg::OP_CONST,  32'h00000004, 10'd0, 6'd0,  0, 11'd0, smeu_pkg::ST_RUN},
        '{smeu_pkg::OP_JMPEQ,  32'h0, 10'd1023, 6'd0, 1, 11'd1023, smeu_pkg::ST_RUN},
        '{smeu_pkg::OP_JMP,    32'h0,        10'd0, 6'd0,  1, 11'd0, smeu_pkg::ST_RUN},
        '{smeu_pkg::OP_JMPGT,  32'h0, 10'd1023, 6'd0, 0, 11'd0,    smeu_pkg::ST_RUN}
    };

    function automatic int unsigned eff_len();
        return (prog_len > PROG_MAX) ? PROG_MAX : prog_len;
    endfunction

    // One instruction of the machine: updates the model state and builds the result.
    task automatic execute_model(input logic [3:0] op, input logic [31:0] imm,
                                 input logic [9:0] tgt, input logic [5:0] slot,
                                 output logic [47:0] res);
        int unsigned len;
        int unsigned nxt;
        logic [3:0]  st;
        logic        pvv;
        logic [31:0] pval;
        logic [31:0] l;
        logic [31:0] r;
        logic [31:0] q;
        longint      ls;
        longint      rs;
        logic        take;
        len  = eff_len();
        st   = smeu_pkg::ST_RUN;
        pvv  = 1'b0;
        pval = 32'd0;
        if (halted) begin
            st = halt_code;
        end
        else begin
            nxt = run_pc + 1;
            if (run_pc >= len) begin
                st = smeu_pkg::ST_PASTEND;
            end
            else begin
                case (op)
                    smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL,
                    smeu_pkg::OP_DIV, smeu_pkg::OP_JMPEQ, smeu_pkg::OP_JMPGT,
                    smeu_pkg::OP_JMPLT:
                    begin
                        if (sp < 2) begin
                            st = smeu_pkg::ST_UNDER;
                        end
                        else begin
                            r    = stk[sp-1];
                            l    = stk[sp-2];
                            ls   = longint'($signed(l));
                            rs   = longint'($signed(r));
                            q    = 32'd0;
                            take = 1'b0;
                            case (op)
                                smeu_pkg::OP_ADD: q = l + r;
                                smeu_pkg::OP_SUB: q = l - r;
                                smeu_pkg::OP_MUL: q = l * r;
                                smeu_pkg::OP_DIV:
                                begin
                                    if (rs == 0) st = smeu_pkg::ST_DIVZERO;
                                    else q = 32'(ls / rs);
                                end
                                smeu_pkg::OP_JMPEQ: take = (ls == rs);
                                smeu_pkg::OP_JMPGT: take = (ls > rs);
                                default:  take = (ls < rs);
                            endcase
                            if (take) begin
                                if (tgt >= len) st = smeu_pkg::ST_BADJUMP;
                                else nxt = tgt;
                            end
                            if (st == smeu_pkg::ST_RUN) begin
                                sp = sp - 2;
                                if (op <= smeu_pkg::OP_DIV) begin
                                    stk[sp] = q;
                                    sp = sp + 1;
                                end
                            end
                        end
                    end
                    smeu_pkg::OP_ASSIGN:
                    begin
                        if (sp < 1) begin
                            st = smeu_pkg::ST_UNDER;
                        end
                        else begin
                            sp = sp - 1;
                            var_val[slot] = stk[sp];
                            var_def[slot] = 1'b1;
                        end
                    end
                    smeu_pkg::OP_VAR, smeu_pkg::OP_CONST:
                    begin
                        if (op == smeu_pkg::OP_VAR && !var_def[slot]) st = smeu_pkg::ST_UNDEF;
                        else if (sp >= STK_DEPTH) st = smeu_pkg::ST_OVER;
                        else begin
                            stk[sp] = (op == smeu_pkg::OP_VAR) ? var_val[slot] : imm;
                            sp = sp + 1;
                        end
                    end
                    smeu_pkg::OP_JMP:
                    begin
                        if (tgt >= len) st = smeu_pkg::ST_BADJUMP;
                        else nxt = tgt;
                    end
                    smeu_pkg::OP_PRINT:
                    begin
                        if (!var_def[slot]) st = smeu_pkg::ST_UNDEF;
                        else begin
                            pval = var_val[slot];
                            pvv  = 1'b1;
                        end
                    end
                    smeu_pkg::OP_HALT:
                        st = (run_pc + 1 == len) ? smeu_pkg::ST_HALTED : smeu_pkg::ST_EARLY;
                    default: st = smeu_pkg::ST_BADOP;
                endcase
            end
            if (st != smeu_pkg::ST_RUN) begin
                halted    = 1'b1;
                halt_code = st;
                pvv       = 1'b0;
                pval      = 32'd0;
            end
            else begin
                run_pc = nxt;
            end
        end
        res = {st, pval, pvv, 11'(run_pc)};
    endtask

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", field, got, want);
        error_count++;
    endtask

    // Sends one instruction, records its expectation at acceptance, then maybe idles.
    task automatic send_instr(input logic [3:0] op, input logic [31:0] imm,
                              input logic [9:0] tgt, input logic [5:0] slot,
                              input bit typed, input logic [10:0] line,
                              input logic [3:0] st);
        logic [47:0] res;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, slot, tgt, imm, op};
        do @(posedge clk); while (!s_tready);
        execute_model(op, imm, tgt, slot, res);
        if (typed) res = {st, 32'd0, 1'b0, line};
        pending_results.push_back(res);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // Lets every result drain and the pipeline settle, then writes the length.
    task automatic write_length(input logic [10:0] value);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        prog_len  = value;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 7))
            0, 1:    return 32'($urandom_range(0, 3));
            2:       return 32'h80000000 + $urandom_range(0, 1);
            3:       return 32'h7fffffff - $urandom_range(0, 1);
            default: return $urandom;
        endcase
    endfunction

    // Builds a random instruction that keeps the machine running.
    task automatic legal_instr(output logic [3:0] op, output logic [31:0] imm,
                               output logic [9:0] tgt, output logic [5:0] slot);
        int unsigned len;
        int          tries;
        len  = eff_len();
        imm  = rand_value();
        tgt  = 10'($urandom_range(0, len - 1));
        slot = 6'($urandom_range(0, SLOTS - 1));
        if (run_pc + 1 >= len) begin
            op = smeu_pkg::OP_JMP;
        end
        else begin
            op = 4'($urandom_range(0, 11));
            if (sp > 48 && $urandom_range(0, 1) == 0) op = smeu_pkg::OP_ASSIGN;
            if (op <= smeu_pkg::OP_DIV
                || (op >= smeu_pkg::OP_JMPEQ && op <= smeu_pkg::OP_JMPLT)) begin
                if (sp < 2) op = smeu_pkg::OP_CONST;
                else if (op == smeu_pkg::OP_DIV && stk[sp-1] == 32'd0) op = smeu_pkg::OP_SUB;
            end
            if (op == smeu_pkg::OP_ASSIGN && sp < 1) op = smeu_pkg::OP_CONST;
            if (op == smeu_pkg::OP_VAR || op == smeu_pkg::OP_PRINT) begin
                tries = 0;
                while (!var_def[slot] && tries < 16) begin
                    slot = 6'($urandom_range(0, SLOTS - 1));
                    tries++;
                end
                if (!var_def[slot]) op = smeu_pkg::OP_CONST;
            end
            if ((op == smeu_pkg::OP_VAR || op == smeu_pkg::OP_CONST) && sp >= STK_DEPTH)
                op = smeu_pkg::OP_ADD;
        end
    endtask

    task automatic random_phase(input int count);
        logic [3:0]  op;
        logic [31:0] imm;
        logic [9:0]  tgt;
        logic [5:0]  slot;
        repeat (count) begin
            legal_instr(op, imm, tgt, slot);
            send_instr(op, imm, tgt, slot, 0, 11'd0, smeu_pkg::ST_RUN);
        end
    endtask

    // Moves the program counter below a new length before it takes effect.
    task automatic retarget(input int unsigned new_len);
        int unsigned lim;
        lim = (new_len > PROG_MAX) ? PROG_MAX : new_len;
        if (lim > eff_len()) lim = eff_len();
        send_instr(smeu_pkg::OP_JMP, 32'd0, 10'($urandom_range(0, lim - 2)), 6'd0, 0, 11'd0,
                   smeu_pkg::ST_RUN);
        write_length(11'(new_len));
    endtask

    // Clock generation.
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result checking and receiver stall bursts.
    always @(posedge clk) begin
        logic [47:0] want;
        if (!rst_n) begin
            quiet_cycles <= 0;
        end
        else begin
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $display("unexpected result transfer: %h", m_tdata);
                    error_count++;
                end
                else begin
                    want = pending_results.pop_front();
                    if (m_tdata[10:0] !== want[10:0])
                        report_mismatch("next_line", m_tdata[10:0], want[10:0]);
                    if (m_tdata[11] !== want[11])
                        report_mismatch("print_valid", m_tdata[11], want[11]);
                    if (m_tdata[43:12] !== want[43:12])
                        report_mismatch("print_value", $signed(m_tdata[43:12]),
                                        $signed(want[43:12]));
                    if (m_tdata[47:44] !== want[47:44])
                        report_mismatch("status", m_tdata[47:44], want[47:44]);
                end
            end
        end
        if (no_idle) begin
            m_tready <= 1'b1;
        end
        else if (out_stall > 0) begin
            out_stall <= out_stall - 1;
            m_tready  <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0) begin
            out_stall <= $urandom_range(0, 7);
            m_tready  <= 1'b0;
        end
        else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transfer.
    initial begin
        quiet_cycles = 0;
        @(posedge rst_n);
        while (quiet_cycles < STALL_LIMIT) @(posedge clk);
        $display("stack_machine_execute_unit_tb: done, errors");
        $finish;
    end

    // Main stimulus sequence.
    initial begin
        logic [3:0]  op;
        logic [31:0] imm;
        logic [9:0]  tgt;
        logic [5:0]  slot;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        error_count = 0;
        no_idle     = 1'b0;
        out_stall   = 0;
        prog_len    = 1;
        run_pc      = 0;
        sp          = 0;
        halted      = 1'b0;
        halt_code   = smeu_pkg::ST_RUN;
        foreach (stk[i]) stk[i] = '0;
        foreach (var_val[i]) begin
            var_val[i] = '0;
            var_def[i] = 1'b0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the full program length.
        write_length(11'd1024);
        foreach (directed_rows[i])
            send_instr(directed_rows[i].op, directed_rows[i].imm, directed_rows[i].tgt,
                       directed_rows[i].slot, directed_rows[i].typed,
                       directed_rows[i].line, directed_rows[i].st);

        // Random legal code under several lengths, the last stretch without idling.
        random_phase(100);
        retarget(2047);
        random_phase(100);
        retarget($urandom_range(2, 1023));
        random_phase(100);
        retarget(1024);
        no_idle = 1'b1;
        random_phase(100);

        // Stopping sequence: past the end, a proper halt, or whatever random code hits.
        case ($urandom_range(0, 3))
            0: write_length(11'd0);
            1: write_length(11'd1);
            2:
            begin
                send_instr(smeu_pkg::OP_JMP, 32'd0, 10'(eff_len() - 1), 6'd0, 0, 11'd0,
                           smeu_pkg::ST_RUN);
                send_instr(smeu_pkg::OP_HALT, 32'd0, 10'd0, 6'd0, 0, 11'd0,
                           smeu_pkg::ST_RUN);
            end
            default: ;
        endcase
        repeat (30) begin
            op   = 4'($urandom_range(0, 15));
            imm  = rand_value();
            tgt  = 10'($urandom);
            slot = 6'($urandom);
            if ((op == smeu_pkg::OP_VAR || op == smeu_pkg::OP_PRINT) && !var_def[slot]
                && !halted)
                op = smeu_pkg::OP_CONST;
            send_instr(op, imm, tgt, slot, 0, 11'd0, smeu_pkg::ST_RUN);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("stack_machine_execute_unit_tb: done, clean");
        else
            $display("stack_machine_execute_unit_tb: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/smeu_pkg.sv
hw/rtl/smeu_ram.sv
hw/rtl/smeu_ctrl.sv
hw/rtl/smeu_dp.sv
hw/rtl/stack_machine_execute_unit.sv
tb/sv/stack_machine_execute_unit_tb.sv
